[hdl/gear_est_pkg.sv]
// Shared widths, constants and codes of the gear estimator.
`default_nettype none
package gear_est_pkg;

    localparam int RPM_W     = 14;
    localparam int SPD_W     = 12;
    localparam int CONST_W   = 32;
    localparam int RANGE_W   = 52;
    localparam int RATIO_W   = 24;
    localparam int GEAR_W    = 4;
    localparam int DEC_W     = 2;
    localparam int CFG_IDX_W = 3;

    // Ratio numerator is rpm * 2^36, denominator is speed * constant.
    localparam int NUM_SHIFT = 36;
    localparam int NUM_W     = RPM_W + NUM_SHIFT;
    localparam int DEN_W     = SPD_W + CONST_W;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);

    localparam logic [CONST_W-1:0] RATIO_CONST_RST = 32'h0001_0000;
    localparam logic [RPM_W-1:0]   IDLE_RPM        = 14'd800;
    localparam logic [SPD_W-1:0]   STOP_SPEED_X16  = 12'd80;

    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_CONST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_BASE  = 3'd2;

    typedef enum logic [DEC_W-1:0] {
        DEC_ZERO  = 2'd0,
        DEC_MATCH = 2'd1,
        DEC_IDLE  = 2'd2,
        DEC_HELD  = 2'd3
    } t_decision;

endpackage
`default_nettype wire

[hdl/gear_est_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module gear_est_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [gear_est_pkg::NUM_W-1:0]    i_num,
    input  wire logic [gear_est_pkg::DEN_W-1:0]    i_den,
    output logic                                   o_done,
    output logic [gear_est_pkg::NUM_W-1:0]         o_quot
);

    logic [gear_est_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [gear_est_pkg::DEN_W-1:0]     r_rem;
    logic [gear_est_pkg::NUM_W-1:0]     r_quo;
    logic [gear_est_pkg::DEN_W-1:0]     r_den;
    logic                               r_done;
    logic [gear_est_pkg::DEN_W:0]       w_trial;
    logic                               w_fit;

    // Shift the next numerator bit into the partial remainder and try the subtract.
    always_comb begin
        w_trial = {r_rem, r_quo[gear_est_pkg::NUM_W-1]};
        w_fit   = (w_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= gear_est_pkg::DIV_CNT_W'(gear_est_pkg::NUM_W);
                r_rem <= '0;
                r_quo <= i_num;
                r_den <= i_den;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (w_fit) begin
                    r_rem <= gear_est_pkg::DEN_W'(w_trial - {1'b0, r_den});
                end else begin
                    r_rem <= w_trial[gear_est_pkg::DEN_W-1:0];
                end
                r_quo <= {r_quo[gear_est_pkg::NUM_W-2:0], w_fit};
                if (r_cnt == gear_est_pkg::DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
`default_nettype wire

[hdl/gear_estimator_ratio_table.sv]
// Top level of the gear estimator: sequencer, range table and result register.
//
// Usage: one input beat carries engine rpm and road speed (km/h x16); each
// input beat yields exactly one result beat with a gear code and a decision.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// The input stalls from acceptance until the result is handed to the output
// register, so one item is in flight at a time.
// A sample with zero rpm or zero speed goes from acceptance straight to the
// result load. Any other sample passes through the speed x constant product,
// the divider start, the bit-serial divider (one quotient bit per cycle of
// the 50-bit numerator), the ratio saturation and the range search (one range
// word per cycle), then the result load. The shared divider takes no new sample
// before the last one is through.
// The output register decouples the receiver: while it stalls, the finished
// result holds and the sequencer waits with the next result only.
// Reset (synchronous, active low) stalls the input, clears the sequencer, the held
// gear (neutral) and the output valid, and loads the configuration defaults:
// ratio constant 1.0, no ranges in use, all range words zero.
// Configuration must be written via a plain write port only while idle; not enforced.
`default_nettype none
module gear_estimator_ratio_table #(
    parameter int MAX_RANGES = 6
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // input channel
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic [gear_est_pkg::RPM_W-1:0]         i_engine_rpm,
    input  wire logic [gear_est_pkg::SPD_W-1:0]         i_speed_x16,
    // output channel
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic [gear_est_pkg::GEAR_W-1:0]             o_gear_code,
    output logic [gear_est_pkg::DEC_W-1:0]              o_decision,
    // configuration write port
    input  wire logic                                   i_cfg_we,
    input  wire logic [gear_est_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [gear_est_pkg::RANGE_W-1:0]       i_cfg_data
);

    localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam logic [2:0] MAX_CNT = 3'(MAX_RANGES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_START,
        S_DIV,
        S_SEARCH,
        S_DONE
    } t_state;

    // configuration registers
    logic [gear_est_pkg::CONST_W-1:0] r_ratio_const;
    logic [2:0]                       r_range_count;
    logic [gear_est_pkg::RANGE_W-1:0] r_range [MAX_RANGES];
    logic [2:0]                       w_cfg_slot;

    // sequencer and datapath registers
    t_state                           r_state, n_state;
    logic [gear_est_pkg::RPM_W-1:0]   r_rpm, n_rpm;
    logic [gear_est_pkg::SPD_W-1:0]   r_spd, n_spd;
    logic [gear_est_pkg::DEN_W-1:0]   r_den, n_den;
    logic [gear_est_pkg::RATIO_W-1:0] r_ratio, n_ratio;
    logic [2:0]                       r_idx, n_idx;
    logic [gear_est_pkg::GEAR_W-1:0]  r_gear_res, n_gear_res;
    gear_est_pkg::t_decision          r_dec_res, n_dec_res;
    logic [gear_est_pkg::GEAR_W-1:0]  r_held, n_held;
    logic                             r_out_valid, n_out_valid;
    logic [gear_est_pkg::GEAR_W-1:0]  r_out_gear, n_out_gear;
    gear_est_pkg::t_decision          r_out_dec, n_out_dec;

    logic                             w_in_take;
    logic                             w_out_free;
    logic [2:0]                       w_limit;
    logic [gear_est_pkg::RANGE_W-1:0] w_word;
    logic [gear_est_pkg::RATIO_W-1:0] w_lo, w_hi;
    logic [gear_est_pkg::DEN_W-1:0]   w_prod;
    logic [gear_est_pkg::NUM_W-1:0]   w_num;
    logic [gear_est_pkg::NUM_W-1:0]   w_quot;
    logic                             w_div_start;
    logic                             w_div_done;

    // Configuration writes; index beyond the table is dropped.
    assign w_cfg_slot = i_cfg_idx - gear_est_pkg::CFG_RANGE_BASE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio_const <= gear_est_pkg::RATIO_CONST_RST;
            r_range_count <= '0;
            for (int k = 0; k < MAX_RANGES; k++) begin
                r_range[k] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == gear_est_pkg::CFG_RATIO_CONST) begin
                r_ratio_const <= i_cfg_data[gear_est_pkg::CONST_W-1:0];
            end else if (i_cfg_idx == gear_est_pkg::CFG_RANGE_COUNT) begin
                r_range_count <= i_cfg_data[2:0];
            end else if (i_cfg_idx >= gear_est_pkg::CFG_RANGE_BASE && w_cfg_slot < MAX_CNT) begin
                r_range[w_cfg_slot[IDX_W-1:0]] <= i_cfg_data;
            end
        end
    end

    // Shared divider: ratio = rpm * 2^36 / (speed * constant).
    assign w_num       = {r_rpm, {gear_est_pkg::NUM_SHIFT{1'b0}}};
    assign w_div_start = (r_state == S_START);

    gear_est_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_in_take  = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_limit    = (r_range_count > MAX_CNT) ? MAX_CNT : r_range_count;
    assign w_word     = r_range[r_idx[IDX_W-1:0]];
    assign w_lo       = w_word[gear_est_pkg::RATIO_W-1:0];
    assign w_hi       = w_word[2*gear_est_pkg::RATIO_W-1:gear_est_pkg::RATIO_W];
    assign w_prod     = r_spd * r_ratio_const;

    always_comb begin
        n_state     = r_state;
        n_rpm       = r_rpm;
        n_spd       = r_spd;
        n_den       = r_den;
        n_ratio     = r_ratio;
        n_idx       = r_idx;
        n_gear_res  = r_gear_res;
        n_dec_res   = r_dec_res;
        n_held      = r_held;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_gear  = r_out_gear;
        n_out_dec   = r_out_dec;

        case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    n_rpm = i_engine_rpm;
                    n_spd = i_speed_x16;
                    if (i_engine_rpm == '0 || i_speed_x16 == '0) begin
                        n_gear_res = '0;
                        n_dec_res  = gear_est_pkg::DEC_ZERO;
                        n_state    = S_DONE;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_den   = w_prod;
                n_state = S_START;
            end
            S_START: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                // Saturate the quotient to the Q8.16 range.
                if (w_div_done) begin
                    if (|w_quot[gear_est_pkg::NUM_W-1:gear_est_pkg::RATIO_W]) begin
                        n_ratio = '1;
                    end else begin
                        n_ratio = w_quot[gear_est_pkg::RATIO_W-1:0];
                    end
                    n_idx   = '0;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                // One range word per cycle, first hit wins.
                if (r_idx >= w_limit) begin
                    if (r_rpm > gear_est_pkg::IDLE_RPM && r_spd < gear_est_pkg::STOP_SPEED_X16) begin
                        n_gear_res = '0;
                        n_dec_res  = gear_est_pkg::DEC_IDLE;
                    end else begin
                        n_gear_res = r_held;
                        n_dec_res  = gear_est_pkg::DEC_HELD;
                    end
                    n_state = S_DONE;
                end else if (r_ratio >= w_lo && r_ratio <= w_hi) begin
                    n_gear_res = w_word[gear_est_pkg::RANGE_W-1:2*gear_est_pkg::RATIO_W];
                    n_dec_res  = gear_est_pkg::DEC_MATCH;
                    n_state    = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DONE: begin
                // Hold until the output register is free, then load it and the held gear.
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_gear  = r_gear_res;
                    n_out_dec   = r_dec_res;
                    n_held      = r_gear_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
            r_rpm       <= n_rpm;
            r_spd       <= n_spd;
            r_den       <= n_den;
            r_ratio     <= n_ratio;
            r_idx       <= n_idx;
            r_gear_res  <= n_gear_res;
            r_dec_res   <= n_dec_res;
            r_out_gear  <= n_out_gear;
            r_out_dec   <= n_out_dec;
        end
    end

    // Hold the input off while reset is applied.
    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_gear_code = r_out_gear;
    assign o_decision  = r_out_dec;

`ifndef NO_ASSERTIONS
    // An accepted sample keeps the input stalled in the next cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting a beat");

    // The shown result always agrees with the stored gear.
    a_held_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_held == o_gear_code))
        else $error("held gear differs from presented gear");

    // Neutral decisions carry gear zero.
    a_neutral_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_decision == gear_est_pkg::DEC_ZERO
                         || o_decision == gear_est_pkg::DEC_IDLE)) |-> (o_gear_code == '0))
        else $error("neutral decision with nonzero gear");

    // The divider reports done only while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider done outside of divide state");
`endif

endmodule
`default_nettype wire
